// ===== hw/rtl/rpm_pkg.sv =====
// rpm_pkg: shared types, widths and constants of the windowed rms power meter
// no dependencies; used by rpm_alu, rpm_core and windowed_rms_power_meter_unit
package rpm_pkg;

  localparam int unsigned AdcW     = 10;
  localparam int unsigned MvW      = 12;
  localparam int unsigned OffW     = 12;
  localparam int unsigned DW       = 13;
  localparam int unsigned SqW      = 24;
  localparam int unsigned SumW     = 40;
  localparam int unsigned CntW     = 16;
  localparam int unsigned WlenW    = 16;
  localparam int unsigned LvW      = 9;
  localparam int unsigned PwrW     = 20;
  localparam int unsigned SlotW    = 11;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned QW       = 32;
  localparam int unsigned RemW     = CntW;
  localparam int unsigned RootW    = QW / 2;
  localparam int unsigned SremW    = RootW + 2;
  localparam int unsigned PmW      = 25;
  localparam int unsigned IterW    = $clog2(QW);

  localparam int unsigned AluW     = SumW;
  localparam int unsigned MulW     = 25;
  localparam int unsigned ProdW    = 2 * MulW;

  localparam int unsigned LogDepth = 2000;

  // mv = (adc * MvRecip) >> MvShift equals floor(adc * 3300 / 1023) for all adc
  localparam logic [21:0] MvRecip    = 22'd3382504;
  localparam int unsigned MvShift    = 20;
  localparam logic [MvW-1:0] MvMid   = 12'd1650;
  // x / 33 as (x * Div33Recip) >> Div33Shift, exact for x below 2**25
  localparam logic [PmW-1:0] Div33Recip = 25'd32537632;
  localparam int unsigned Div33Shift    = 30;

  localparam logic [CntW-2:0] FreqLo = 15'd25;
  localparam logic [CntW-2:0] FreqHi = 15'd75;

  localparam logic [WlenW-1:0] WlenReset = 16'd1000;
  localparam logic [LvW-1:0]   LvReset   = 9'd230;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_LINE_VOLTAGE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [PwrW-1:0]  power;
    logic [PwrW-1:0]  peak;
    logic             rejected;
    logic             logged;
    logic [SlotW-1:0] slot;
  } result_t;

endpackage

// ===== hw/rtl/rpm_alu.sv =====
// rpm_alu: shared add, subtract and multiply unit of the power meter
// depends on rpm_pkg; the sub result carries the borrow in bit AluW
module rpm_alu (
  input  rpm_pkg::alu_req_t          req_i,
  output logic [rpm_pkg::ProdW-1:0]  res_o
);
  import rpm_pkg::*;

  logic [MulW-1:0]  mul_a;
  logic [MulW-1:0]  mul_b;
  logic [ProdW-1:0] prod;

  assign mul_a = req_i.a[MulW-1:0];
  assign mul_b = req_i.b[MulW-1:0];
  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    case (req_i.op)
      ALU_ADD: res_o = ProdW'({1'b0, req_i.a} + {1'b0, req_i.b});
      ALU_SUB: res_o = ProdW'({1'b0, req_i.a} - {1'b0, req_i.b});
      ALU_MUL: res_o = prod;
      default: res_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/rpm_core.sv =====
// rpm_core: sequencer and window state, uses rpm_alu; per sample conversion and
// accumulation; in-range window close: bit serial divide, square root, power scale
module rpm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpm_pkg::AdcW-1:0]      adc_i,
  input  logic [rpm_pkg::WlenW-1:0]     wlen_i,
  input  logic [rpm_pkg::LvW-1:0]       lv_i,
  input  logic                          out_busy_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output rpm_pkg::result_t              res_o
);
  import rpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MV,
    S_SQ,
    S_ACC,
    S_CHK,
    S_DIV,
    S_SQRT,
    S_PWR_MUL,
    S_PWR_DIV,
    S_FIN
  } state_e;

  state_e            state_q;
  logic [AdcW-1:0]   adc_q;
  logic [MvW-1:0]    mv_q;
  logic [SqW-1:0]    sq_q;
  logic [OffW-1:0]   prev_off_q;
  logic [1:0]        sign_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cross_q;
  logic [RemW-1:0]   rem_q;
  logic [QW-1:0]     dq_q;
  logic [SremW-1:0]  srem_q;
  logic [RootW-1:0]  root_q;
  logic [IterW-1:0]  iter_q;
  logic [PmW-1:0]    pm_q;
  logic [PwrW-1:0]   power_q;
  logic              rej_q;
  logic [PwrW-1:0]   peak_q;
  logic [SlotW-1:0]  log_cnt_q;

  alu_req_t          alu_req;
  logic [ProdW-1:0]  alu_res;
  logic              borrow;

  logic signed [DW-1:0] off_w;
  logic signed [DW-1:0] d_w;
  logic [MvW-1:0]       mag_w;
  logic                 pos_w;
  logic                 neg_w;
  logic                 cross_w;
  logic                 close_w;
  logic [CntW-2:0]      freq_w;
  logic                 freq_ok_w;

  logic [RemW-1:0]   rem_d;
  logic [QW-1:0]     dq_d;
  logic [SremW-1:0]  srem_d;
  logic [RootW-1:0]  root_d;
  logic [PwrW-1:0]   peak_d;
  logic              log_ok;

  rpm_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign borrow = alu_res[AluW];

  // sample conversion: centered offset, two sample sum, sign and magnitude
  assign off_w   = $signed({1'b0, mv_q}) - $signed({1'b0, MvMid});
  assign d_w     = off_w + $signed({prev_off_q[OffW-1], prev_off_q});
  assign neg_w   = d_w[DW-1];
  assign pos_w   = !d_w[DW-1] && (d_w != '0);
  assign mag_w   = neg_w ? MvW'(-d_w) : MvW'(d_w);
  assign cross_w = (pos_w && sign_q[1]) || (neg_w && sign_q[0]);

  assign close_w   = (cnt_q != '0) && (cnt_q >= wlen_i);
  assign freq_w    = cross_q[CntW-1:1];
  assign freq_ok_w = (freq_w >= FreqLo) && (freq_w <= FreqHi);

  // restoring divide and square root steps
  assign rem_d  = borrow ? {rem_q[RemW-2:0], dq_q[QW-1]} : alu_res[RemW-1:0];
  assign dq_d   = {dq_q[QW-2:0], !borrow};
  assign srem_d = borrow ? {srem_q[SremW-3:0], dq_q[QW-1:QW-2]} : alu_res[SremW-1:0];
  assign root_d = {root_q[RootW-2:0], !borrow};

  assign peak_d = (power_q > peak_q) ? power_q : peak_q;
  assign log_ok = log_cnt_q < SlotW'(LogDepth);

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_q)
      S_MV: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AluW'(adc_q);
        alu_req.b  = AluW'(MvRecip);
      end
      S_SQ: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AluW'(mag_w);
        alu_req.b  = AluW'(mag_w);
      end
      S_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = AluW'(sum_q);
        alu_req.b  = AluW'(sq_q);
      end
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = AluW'({rem_q, dq_q[QW-1]});
        alu_req.b  = AluW'(cnt_q);
      end
      S_SQRT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = AluW'({srem_q, dq_q[QW-1:QW-2]});
        alu_req.b  = AluW'({root_q, 2'b01});
      end
      S_PWR_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AluW'(root_q);
        alu_req.b  = AluW'(lv_i);
      end
      S_PWR_DIV: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AluW'(pm_q);
        alu_req.b  = AluW'(Div33Recip);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      adc_q      <= '0;
      mv_q       <= '0;
      sq_q       <= '0;
      prev_off_q <= '0;
      sign_q     <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      cross_q    <= '0;
      rem_q      <= '0;
      dq_q       <= '0;
      srem_q     <= '0;
      root_q     <= '0;
      iter_q     <= '0;
      pm_q       <= '0;
      power_q    <= '0;
      rej_q      <= 1'b0;
      peak_q     <= '0;
      log_cnt_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            adc_q   <= adc_i;
            state_q <= S_MV;
          end
        end
        S_MV: begin
          mv_q    <= alu_res[MvShift+MvW-1:MvShift];
          state_q <= S_SQ;
        end
        S_SQ: begin
          sq_q       <= alu_res[SqW-1:0];
          prev_off_q <= OffW'(off_w);
          sign_q     <= {neg_w, pos_w};
          if (cross_w) begin
            cross_q <= cross_q + 1'b1;
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_q   <= alu_res[SumW-1:0];
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (!close_w) begin
            state_q <= S_IDLE;
          end else if (freq_ok_w) begin
            rem_q   <= sum_q[SumW-1:SumW-RemW];
            dq_q    <= {sum_q[SumW-RemW-1:0], 8'b0};
            iter_q  <= IterW'(QW - 1);
            rej_q   <= 1'b0;
            state_q <= S_DIV;
          end else begin
            power_q <= '0;
            rej_q   <= 1'b1;
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          rem_q  <= rem_d;
          dq_q   <= dq_d;
          iter_q <= iter_q - 1'b1;
          if (iter_q == '0) begin
            srem_q  <= '0;
            root_q  <= '0;
            iter_q  <= IterW'(RootW - 1);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem_q <= srem_d;
          root_q <= root_d;
          dq_q   <= {dq_q[QW-3:0], 2'b00};
          iter_q <= iter_q - 1'b1;
          if (iter_q == '0) begin
            state_q <= S_PWR_MUL;
          end
        end
        S_PWR_MUL: begin
          pm_q    <= alu_res[PmW-1:0];
          state_q <= S_PWR_DIV;
        end
        S_PWR_DIV: begin
          power_q <= alu_res[Div33Shift+PwrW-1:Div33Shift];
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_busy_i) begin
            peak_q  <= peak_d;
            if (log_ok) begin
              log_cnt_q <= log_cnt_q + 1'b1;
            end
            sum_q   <= '0;
            cnt_q   <= '0;
            cross_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign res_valid_o    = (state_q == S_FIN) && !out_busy_i;
  assign res_o.power    = power_q;
  assign res_o.peak     = peak_d;
  assign res_o.rejected = rej_q;
  assign res_o.logged   = log_ok;
  assign res_o.slot     = log_ok ? log_cnt_q : '0;

endmodule

// ===== hw/rtl/windowed_rms_power_meter_unit.sv =====
// windowed_rms_power_meter_unit: top level with configuration registers and
// result output register; depends on rpm_pkg and rpm_core
//
// Input channel: one 10-bit current sample per request (in_valid_i/in_stall_o).
// Output channel: one request per finished window (out_valid_o/out_stall_i)
// carrying power, peak power, noise reject flag and log slot.
// Configuration: cfg_we_i writes window length (index 0) or line voltage
// (index 1) from cfg_wdata_i in the same cycle.
// A sample that does not close a window keeps the block busy through the MV,
// SQ, ACC and CHK states after it is taken; no sample is taken while busy.
// A closing window whose crossing rate is in range needs a 32 step divide and
// a 16 step square root in the shared unit, then PWR_MUL, PWR_DIV and FIN;
// the next sample is taken no earlier than its result shows on the output.
// A rejected window goes from CHK straight to FIN to give its result.
// The output register holds a result while the receiver stalls; a sample can
// still be taken then, but the next result waits in the core until the
// register is free.
// Reset clears all window state, the peak and the log count, and restores the
// default window length of 1000 and line voltage of 230.
module windowed_rms_power_meter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rpm_pkg::AdcW-1:0]      adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpm_pkg::PwrW-1:0]      power_q4_o,
  output logic [rpm_pkg::PwrW-1:0]      peak_power_q4_o,
  output logic                          noise_rejected_o,
  output logic                          logged_o,
  output logic [rpm_pkg::SlotW-1:0]     log_slot_o,
  input  logic                          cfg_we_i,
  input  logic [rpm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [rpm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import rpm_pkg::*;

  logic [WlenW-1:0] wlen_q;
  logic [LvW-1:0]   lv_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             busy;
  logic             start;
  logic             out_busy;
  logic             res_valid;
  result_t          res;

  assign start    = in_valid_i && !busy;
  assign out_busy = out_valid_q && out_stall_i;

  rpm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .adc_i       (adc_sample_i),
    .wlen_i      (wlen_q),
    .lv_i        (lv_q),
    .out_busy_i  (out_busy),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WlenReset;
      lv_q   <= LvReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_WINDOW_LENGTH: wlen_q <= cfg_wdata_i[WlenW-1:0];
        CFG_LINE_VOLTAGE:  lv_q   <= cfg_wdata_i[LvW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign in_stall_o       = busy;
  assign out_valid_o      = out_valid_q;
  assign power_q4_o       = out_q.power;
  assign peak_power_q4_o  = out_q.peak;
  assign noise_rejected_o = out_q.rejected;
  assign logged_o         = out_q.logged;
  assign log_slot_o       = out_q.slot;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && noise_rejected_o |-> power_q4_o == '0)
    else $error("rejected window with nonzero power");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_power_q4_o >= power_q4_o)
    else $error("peak below window power");

  a_slot_unlogged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !logged_o |-> log_slot_o == '0)
    else $error("slot set without log entry");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && logged_o |-> log_slot_o < SlotW'(LogDepth))
    else $error("log slot out of range");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of windowed_rms_power_meter_unit; sends adc
// sample requests and register writes, predicts every window result locally
// and checks it field by field; depends on rpm_pkg and the rtl top level
module tb_top;
  import rpm_pkg::*;

  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned TimeoutCycles = 2_000_000;
  localparam int unsigned LogFull       = 2000;
  localparam int unsigned RandomItems   = 650;
  localparam logic [WlenW-1:0] WlenDefault = 16'd1000;
  localparam logic [LvW-1:0]   LvDefault   = 9'd230;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [AdcW-1:0]     adc_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [PwrW-1:0]     power_q4_o;
  logic [PwrW-1:0]     peak_power_q4_o;
  logic                noise_rejected_o;
  logic                logged_o;
  logic [SlotW-1:0]    log_slot_o;
  logic                cfg_we_i     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;

  logic [WlenW-1:0] cfg_wlen;
  logic [LvW-1:0]   cfg_lv;
  int               meter_prev_off;
  int               meter_prev_sgn;
  logic [SumW-1:0]  meter_sum;
  logic [CntW-1:0]  meter_cnt;
  logic [CntW-1:0]  meter_cross;
  logic [PwrW-1:0]  meter_peak;
  int unsigned      meter_log_used;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      errors;
  result_t          window_expect_q[$];
  logic [AdcW-1:0]  sample_q[$];

  windowed_rms_power_meter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .adc_sample_i    (adc_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .power_q4_o      (power_q4_o),
    .peak_power_q4_o (peak_power_q4_o),
    .noise_rejected_o(noise_rejected_o),
    .logged_o        (logged_o),
    .log_slot_o      (log_slot_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic meter_step(input logic [AdcW-1:0] adc);
    int              mv;
    int              off;
    int              d;
    int              sgn;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned scaled;
    logic [CntW-1:0] freq;
    result_t         res;
    mv  = (int'(adc) * 3300) / 1023;
    off = mv - 1650;
    d   = off + meter_prev_off;
    sgn = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    mag = (d < 0) ? -d : d;
    if (sgn * meter_prev_sgn < 0) meter_cross = meter_cross + 1'b1;
    meter_sum      = meter_sum + SumW'(mag * mag);
    meter_cnt      = meter_cnt + 1'b1;
    meter_prev_off = off;
    meter_prev_sgn = sgn;
    if (meter_cnt != 0 && meter_cnt >= cfg_wlen) begin
      freq         = meter_cross >> 1;
      res          = '0;
      res.rejected = 1'b1;
      if (freq >= 25 && freq <= 75) begin
        root         = floor_sqrt((64'(meter_sum) << 8) / 64'(meter_cnt));
        scaled       = (root * 64'(cfg_lv)) / 33;
        res.power    = PwrW'(scaled);
        res.rejected = 1'b0;
      end
      if (res.power > meter_peak) meter_peak = res.power;
      res.peak = meter_peak;
      if (meter_log_used < LogFull) begin
        res.logged = 1'b1;
        res.slot   = SlotW'(meter_log_used);
        meter_log_used++;
      end
      window_expect_q.push_back(res);
      meter_sum   = '0;
      meter_cnt   = '0;
      meter_cross = '0;
    end
  endtask

  task automatic report_field(input string name, input logic [PwrW-1:0] want,
                              input logic [PwrW-1:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_window();
    result_t want;
    if (window_expect_q.size() == 0) begin
      $display("%0t unexpected result expected none actual power_q4 %0d", $time, power_q4_o);
      errors++;
    end else begin
      want = window_expect_q.pop_front();
      report_field("power_q4", want.power, power_q4_o);
      report_field("peak_power_q4", want.peak, peak_power_q4_o);
      report_field("noise_rejected", PwrW'(want.rejected), PwrW'(noise_rejected_o));
      report_field("logged", PwrW'(want.logged), PwrW'(logged_o));
      report_field("log_slot", PwrW'(want.slot), PwrW'(log_slot_o));
    end
  endtask

  // sample request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      adc_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) meter_step(adc_sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          adc_sample_i <= sample_q.pop_front();
        end else begin
          in_valid_i   <= 1'b0;
          adc_sample_i <= AdcW'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_window();
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic settle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || window_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) cfg_wlen = val;
    else cfg_lv = val[LvW-1:0];
    @(negedge clk_i);
  endtask

  // four point wave around mid scale, two average sign changes per period
  function automatic logic [AdcW-1:0] tone_sample(input int k, input int amp_a, input int amp_b);
    int level;
    if ($urandom_range(0, 49) == 0) return AdcW'($urandom);
    case (k % 4)
      0:       level = amp_a;
      1:       level = amp_b;
      2:       level = -amp_a;
      default: level = -amp_b;
    endcase
    level = 508 + level + int'($urandom_range(0, 8));
    if (level < 0) level = 0;
    if (level > 1023) level = 1023;
    return AdcW'(level);
  endfunction

  task automatic random_phase(inout int unsigned items);
    int unsigned kind;
    int unsigned pick;
    int unsigned wlen;
    int unsigned n;
    int          amp_a;
    int          amp_b;
    kind   = $urandom_range(0, 2);
    pick   = $urandom_range(0, 9);
    if (pick == 0) set_reg(CFG_LINE_VOLTAGE, 16'd0);
    else if (pick == 1) set_reg(CFG_LINE_VOLTAGE, 16'd511);
    else if (pick == 2) set_reg(CFG_LINE_VOLTAGE, CfgDataW'($urandom));
    else if (pick < 7) set_reg(CFG_LINE_VOLTAGE, CfgDataW'($urandom_range(0, 511)));
    if (kind == 0) begin
      wlen = $urandom_range(0, 8);
      n    = $urandom_range(8, 30);
      set_reg(CFG_WINDOW_LENGTH, CfgDataW'(wlen));
      repeat (n) sample_q.push_back(AdcW'($urandom));
    end else begin
      wlen  = ($urandom_range(0, 4) == 0) ? $urandom_range(92, 320) : $urandom_range(100, 160);
      n     = wlen * $urandom_range(1, 3) + $urandom_range(0, 20);
      amp_a = $urandom_range(100, 511);
      amp_b = $urandom_range(10, amp_a - 1);
      set_reg(CFG_WINDOW_LENGTH, CfgDataW'(wlen));
      for (int k = 0; k < n; k++) sample_q.push_back(tone_sample(k, amp_a, amp_b));
    end
    settle();
    items += n;
  endtask

  initial begin
    int unsigned rnd_items;
    errors         = 0;
    cfg_wlen       = WlenDefault;
    cfg_lv         = LvDefault;
    meter_prev_off = 0;
    meter_prev_sgn = 0;
    meter_sum      = '0;
    meter_cnt      = '0;
    meter_cross    = '0;
    meter_peak     = '0;
    meter_log_used = 0;
    send_idle_pct  = 16;
    recv_idle_pct  = 88;
    rnd_items      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // partial window at the default length, then the length drops below it
    sample_q.push_back(10'd0);
    sample_q.push_back(10'd1023);
    sample_q.push_back(10'd512);
    settle();
    set_reg(CFG_WINDOW_LENGTH, 16'd1);
    sample_q.push_back(10'd1023);
    sample_q.push_back(10'd0);
    sample_q.push_back(10'd1023);
    sample_q.push_back(10'd511);
    sample_q.push_back(10'd512);
    settle();
    // zero length closes on every sample
    set_reg(CFG_WINDOW_LENGTH, 16'd0);
    sample_q.push_back(10'd1023);
    sample_q.push_back(10'd0);
    sample_q.push_back(10'd1);
    settle();
    set_reg(CFG_WINDOW_LENGTH, 16'hFFFF);
    set_reg(CFG_LINE_VOLTAGE, 16'd511);
    repeat (5) sample_q.push_back(AdcW'($urandom));
    settle();
    set_reg(CFG_WINDOW_LENGTH, 16'd3);
    sample_q.push_back(AdcW'($urandom));
    settle();

    while (rnd_items < RandomItems / 3) random_phase(rnd_items);
    send_idle_pct = 88;
    recv_idle_pct = 16;
    while (rnd_items < 2 * RandomItems / 3) random_phase(rnd_items);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (rnd_items < RandomItems) random_phase(rnd_items);
    settle();

    if (errors == 0 && window_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rpm_pkg.sv
hw/rtl/rpm_alu.sv
hw/rtl/rpm_core.sv
hw/rtl/windowed_rms_power_meter_unit.sv
sim/tb_top.sv
